@@ hw/rtl/bezier_subdivide_at_t_macros.svh @@
// ----------------------------------------------------------------------------
// bezier subdivide assertion macros
// shared property forms for the checker of the bezier split block
// ----------------------------------------------------------------------------
`ifndef BEZIER_SUBDIVIDE_AT_T_MACROS_SVH
`define BEZIER_SUBDIVIDE_AT_T_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define BSAT_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bezier split check failed");

// next-cycle implication, quiet while reset is high
`define BSAT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bezier split check failed");

`endif

@@ hw/rtl/bsat_pkg.sv @@
// ----------------------------------------------------------------------------
// bsat_pkg
// shared codes, point selectors and interpolation schedule of the split block
// ----------------------------------------------------------------------------
package bsat_pkg;

   // segment kind carried by each beat
   typedef enum logic {
      MODE_QUAD  = 1'b0,
      MODE_CUBIC = 1'b1
   } mode_type;

   // slots of the working point set
   typedef enum logic [3:0] {
      PT_P0,
      PT_P1,
      PT_P2,
      PT_P3,
      PT_AB,
      PT_BC,
      PT_CD,
      PT_ABC,
      PT_BCD,
      PT_ABCD
   } pt_sel_type;

   localparam int PT_COUNT     = 10;
   localparam int NUM_CTRL     = 4;
   localparam int LERP_LATENCY = 3;
   localparam int NUM_LEVELS   = 3;
   localparam int NUM_OPS      = 6;
   localparam int PIPE_DEPTH   = LERP_LATENCY * NUM_LEVELS;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] LAST_IDX_QUAD  = 3'd4;
   localparam logic [2:0] LAST_IDX_CUBIC = 3'd6;

   typedef logic [1:0] level_type;

   // de casteljau schedule: y = lerp(a, b) at the given level
   localparam pt_sel_type OP_A [NUM_OPS] = '{PT_P0, PT_P1, PT_P2, PT_AB, PT_BC, PT_ABC};
   localparam pt_sel_type OP_B [NUM_OPS] = '{PT_P1, PT_P2, PT_P3, PT_BC, PT_CD, PT_BCD};
   localparam pt_sel_type OP_Y [NUM_OPS] = '{PT_AB, PT_BC, PT_CD, PT_ABC, PT_BCD, PT_ABCD};
   localparam level_type  OP_LEVEL [NUM_OPS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};

   // queue occupancy seen by front and back
   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   // which working point goes out at a given position
   function automatic pt_sel_type point_sel(mode_type mode, logic [2:0] idx);
      pt_sel_type sel;
      unique case ({mode, idx})
         {MODE_QUAD, 3'd0}  : sel = PT_P0;
         {MODE_QUAD, 3'd1}  : sel = PT_AB;
         {MODE_QUAD, 3'd2}  : sel = PT_ABC;
         {MODE_QUAD, 3'd3}  : sel = PT_BC;
         {MODE_QUAD, 3'd4}  : sel = PT_P2;
         {MODE_CUBIC, 3'd0} : sel = PT_P0;
         {MODE_CUBIC, 3'd1} : sel = PT_AB;
         {MODE_CUBIC, 3'd2} : sel = PT_ABC;
         {MODE_CUBIC, 3'd3} : sel = PT_ABCD;
         {MODE_CUBIC, 3'd4} : sel = PT_BCD;
         {MODE_CUBIC, 3'd5} : sel = PT_CD;
         {MODE_CUBIC, 3'd6} : sel = PT_P3;
         default            : sel = PT_P0;
      endcase
      return sel;
   endfunction

   // position of the final point of a segment
   function automatic logic [2:0] last_idx(mode_type mode);
      logic [2:0] idx;
      unique case (mode)
         MODE_QUAD  : idx = LAST_IDX_QUAD;
         MODE_CUBIC : idx = LAST_IDX_CUBIC;
         default    : idx = LAST_IDX_CUBIC;
      endcase
      return idx;
   endfunction

endpackage

@@ hw/rtl/bsat_queue.sv @@
// ----------------------------------------------------------------------------
// bsat_queue
// short fifo between the accepting front and the computing back
// ----------------------------------------------------------------------------
module bsat_queue import bsat_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output q_status_type      status
);

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   // occupancy flags
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.not_empty;

   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/bsat_lerp.sv @@
// ----------------------------------------------------------------------------
// bsat_lerp
// three-stage fixed point interpolation a + ((t * (b - a)) >>> frac)
// ----------------------------------------------------------------------------
module bsat_lerp import bsat_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] a,
   input  logic signed [COORD_WIDTH-1:0] b,
   input  logic        [T_FRAC_BITS:0]   t,
   output logic signed [COORD_WIDTH-1:0] y
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = COORD_WIDTH + T_FRAC_BITS + 3;
   localparam int SW = COORD_WIDTH + 3;

   logic signed [DW-1:0]          d_ff, d_in;
   logic signed [COORD_WIDTH-1:0] a1_ff, a2_ff;
   logic        [T_FRAC_BITS:0]   t1_ff;
   logic signed [T_FRAC_BITS+1:0] t1_s;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [SW-1:0]          shifted;
   logic signed [SW-1:0]          sum;
   logic signed [COORD_WIDTH-1:0] y_ff, y_in;

   // difference, one bit wider than the coordinates
   assign d_in = {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};

   // signed product with non-negative t
   assign t1_s    = {1'b0, t1_ff};
   assign prod_in = d_ff * t1_s;

   // flooring shift is the upper part of the product, then add the start
   assign shifted = prod_ff[PW-1:T_FRAC_BITS];
   assign sum     = {{3{a2_ff[COORD_WIDTH-1]}}, a2_ff} + shifted;
   assign y_in    = sum[COORD_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         a1_ff   <= a;
         t1_ff   <= t;
         prod_ff <= prod_in;
         a2_ff   <= a1_ff;
         y_ff    <= y_in;
      end
   end

   assign y = y_ff;

endmodule

@@ hw/rtl/bsat_front.sv @@
// ----------------------------------------------------------------------------
// bsat_front
// takes request beats, saturates the split parameter and feeds the queue
// ----------------------------------------------------------------------------
module bsat_front import bsat_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int T_FRAC_BITS = 16,
   localparam int ITEM_W = 1 + (T_FRAC_BITS + 1) + 2 * NUM_CTRL * COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic        [T_FRAC_BITS:0]   req_split_t,
   input  logic signed [COORD_WIDTH-1:0] req_p0_x,
   input  logic signed [COORD_WIDTH-1:0] req_p0_y,
   input  logic signed [COORD_WIDTH-1:0] req_p1_x,
   input  logic signed [COORD_WIDTH-1:0] req_p1_y,
   input  logic signed [COORD_WIDTH-1:0] req_p2_x,
   input  logic signed [COORD_WIDTH-1:0] req_p2_y,
   input  logic signed [COORD_WIDTH-1:0] req_p3_x,
   input  logic signed [COORD_WIDTH-1:0] req_p3_y,
   input  q_status_type                  q_status,
   output logic                          push,
   output logic [ITEM_W-1:0]             push_data
);

   localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   logic                  accept;
   logic [T_FRAC_BITS:0]  t_cls;
   mode_type              mode_cls;
   logic [ITEM_W-1:0]     item_ff, item_in;
   logic                  valid_ff, valid_in;

   // split parameter above one saturates to exactly one
   assign t_cls    = (req_split_t[T_FRAC_BITS] && (|req_split_t[T_FRAC_BITS-1:0]))
                     ? T_ONE : req_split_t;
   assign mode_cls = mode_type'(req_mode);

   assign item_in = {mode_cls, t_cls,
                     req_p3_y, req_p2_y, req_p1_y, req_p0_y,
                     req_p3_x, req_p2_x, req_p1_x, req_p0_x};

   // holding register drains into the queue
   assign push      = valid_ff && !q_status.full;
   assign req_stall = valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign push_data = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/bsat_back.sv @@
// ----------------------------------------------------------------------------
// bsat_back
// interpolation pipeline over three levels and the point serialiser
// ----------------------------------------------------------------------------
module bsat_back import bsat_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int T_FRAC_BITS = 16,
   localparam int ITEM_W = 1 + (T_FRAC_BITS + 1) + 2 * NUM_CTRL * COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  q_status_type                  q_status,
   output logic                          pop,
   input  logic [ITEM_W-1:0]             pop_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic        [2:0]             rsp_point_index,
   output logic                          rsp_last
);

   typedef logic [COORD_WIDTH-1:0] coord_type;
   typedef logic [T_FRAC_BITS:0]   t_type;

   typedef struct packed {
      mode_type                  mode;
      t_type                     t;
      coord_type [PT_COUNT-1:0]  x;
      coord_type [PT_COUNT-1:0]  y;
   } bundle_type;

   logic [NUM_CTRL-1:0][COORD_WIDTH-1:0] head_px;
   logic [NUM_CTRL-1:0][COORD_WIDTH-1:0] head_py;
   logic                                 head_mode;
   t_type                                head_t;
   bundle_type                           head;

   bundle_type             pipe_ff [PIPE_DEPTH];
   bundle_type             pipe_in [PIPE_DEPTH];
   logic [PIPE_DEPTH-1:0]  vld_ff, vld_in;
   bundle_type             merged [NUM_LEVELS];
   bundle_type             src [NUM_LEVELS];
   coord_type              lerp_x [NUM_OPS];
   coord_type              lerp_y [NUM_OPS];
   logic                   adv;

   bundle_type             hold_ff;
   logic                   busy_ff, busy_in;
   logic [2:0]             idx_ff, idx_in;
   logic                   take;
   logic                   is_last;
   logic                   load;
   logic                   fin_valid;
   pt_sel_type             sel;

   // unpack the queue head into a working point set
   assign {head_mode, head_t, head_py, head_px} = pop_data;

   always_comb begin
      head            = '0;
      head.mode       = mode_type'(head_mode);
      head.t          = head_t;
      head.x[PT_P0]   = head_px[0];
      head.x[PT_P1]   = head_px[1];
      head.x[PT_P2]   = head_px[2];
      head.x[PT_P3]   = head_px[3];
      head.y[PT_P0]   = head_py[0];
      head.y[PT_P1]   = head_py[1];
      head.y[PT_P2]   = head_py[2];
      head.y[PT_P3]   = head_py[3];
   end

   // fold each level's results into the point set travelling beside it
   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         merged[l] = pipe_ff[l * LERP_LATENCY + LERP_LATENCY - 1];
         for (int op = 0; op < NUM_OPS; op++) begin
            if (OP_LEVEL[op] == level_type'(l)) begin
               merged[l].x[OP_Y[op]] = lerp_x[op];
               merged[l].y[OP_Y[op]] = lerp_y[op];
            end
         end
      end
   end

   // operand source of every level
   assign src[0] = head;
   for (genvar l = 1; l < NUM_LEVELS; l++) begin : g_src
      assign src[l] = merged[l-1];
   end

   // interpolators, one per coordinate and schedule entry
   for (genvar op = 0; op < NUM_OPS; op++) begin : g_op
      bsat_lerp #(
         .COORD_WIDTH (COORD_WIDTH),
         .T_FRAC_BITS (T_FRAC_BITS)
      ) u_lerp_x (
         .clock (clock),
         .en    (adv),
         .a     (src[OP_LEVEL[op]].x[OP_A[op]]),
         .b     (src[OP_LEVEL[op]].x[OP_B[op]]),
         .t     (src[OP_LEVEL[op]].t),
         .y     (lerp_x[op])
      );
      bsat_lerp #(
         .COORD_WIDTH (COORD_WIDTH),
         .T_FRAC_BITS (T_FRAC_BITS)
      ) u_lerp_y (
         .clock (clock),
         .en    (adv),
         .a     (src[OP_LEVEL[op]].y[OP_A[op]]),
         .b     (src[OP_LEVEL[op]].y[OP_B[op]]),
         .t     (src[OP_LEVEL[op]].t),
         .y     (lerp_y[op])
      );
   end

   // side pipeline next values
   for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_pipe
      if (k == 0) begin : g_first
         assign pipe_in[k] = head;
         assign vld_in[k]  = q_status.not_empty;
      end else if ((k % LERP_LATENCY) == 0) begin : g_level
         assign pipe_in[k] = merged[k / LERP_LATENCY - 1];
         assign vld_in[k]  = vld_ff[k-1];
      end else begin : g_pass
         assign pipe_in[k] = pipe_ff[k-1];
         assign vld_in[k]  = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
      end
   end

   // serialiser control
   assign fin_valid = vld_ff[PIPE_DEPTH-1];
   assign take      = busy_ff && !rsp_stall;
   assign is_last   = (idx_ff == last_idx(hold_ff.mode));
   assign load      = fin_valid && (!busy_ff || (take && is_last));
   assign adv       = !fin_valid || load;
   assign pop       = adv && q_status.not_empty;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (take) begin
         if (is_last) begin
            busy_in = 1'b0;
         end
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= merged[NUM_LEVELS-1];
      end
   end

   // response beat fields
   assign sel             = point_sel(hold_ff.mode, idx_ff);
   assign rsp_valid       = busy_ff;
   assign rsp_out_x       = hold_ff.x[sel];
   assign rsp_out_y       = hold_ff.y[sel];
   assign rsp_point_index = idx_ff;
   assign rsp_last        = is_last;

endmodule

@@ hw/rtl/bezier_subdivide_at_t.sv @@
// ----------------------------------------------------------------------------
// bezier_subdivide_at_t
// Splits a quadratic or cubic Bezier segment at t by de Casteljau steps.
// Request channel (req_valid / req_stall): one beat per segment, carrying the
// mode, the Q1.16 split parameter and the Q16.16 control points.
// Response channel (rsp_valid / rsp_stall): one beat per point, 5 for a
// quadratic and 7 for a cubic, with its position and a marker on the final one.
// Path of a request: holding register, queue, nine pipeline stages of
// interpolation, and the output register that presents each point.
// The response channel carries one point per cycle while rsp_stall is low;
// requests keep flowing meanwhile into a two-entry queue and the pipeline.
// Reset clears every valid flag; no point is shown until a new request.
// A stalled response holds its beat; the pipeline and queue then fill and
// req_stall rises until the receiver takes points again.
// ----------------------------------------------------------------------------
module bezier_subdivide_at_t import bsat_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic        [T_FRAC_BITS:0]   req_split_t,
   input  logic signed [COORD_WIDTH-1:0] req_p0_x,
   input  logic signed [COORD_WIDTH-1:0] req_p0_y,
   input  logic signed [COORD_WIDTH-1:0] req_p1_x,
   input  logic signed [COORD_WIDTH-1:0] req_p1_y,
   input  logic signed [COORD_WIDTH-1:0] req_p2_x,
   input  logic signed [COORD_WIDTH-1:0] req_p2_y,
   input  logic signed [COORD_WIDTH-1:0] req_p3_x,
   input  logic signed [COORD_WIDTH-1:0] req_p3_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic        [2:0]             rsp_point_index,
   output logic                          rsp_last
);

   localparam int ITEM_W = 1 + (T_FRAC_BITS + 1) + 2 * NUM_CTRL * COORD_WIDTH;

   q_status_type       q_status;
   logic               push;
   logic [ITEM_W-1:0]  push_data;
   logic               pop;
   logic [ITEM_W-1:0]  pop_data;

   // accept and classify
   bsat_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_split_t (req_split_t),
      .req_p0_x    (req_p0_x),
      .req_p0_y    (req_p0_y),
      .req_p1_x    (req_p1_x),
      .req_p1_y    (req_p1_y),
      .req_p2_x    (req_p2_x),
      .req_p2_y    (req_p2_y),
      .req_p3_x    (req_p3_x),
      .req_p3_y    (req_p3_y),
      .q_status    (q_status),
      .push        (push),
      .push_data   (push_data)
   );

   // decoupling queue
   bsat_queue #(
      .DATA_W (ITEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // interpolate and serialise
   bsat_back #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .pop             (pop),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_point_index (rsp_point_index),
      .rsp_last        (rsp_last)
   );

endmodule

@@ hw/rtl/bsat_checker.sv @@
// ----------------------------------------------------------------------------
// bsat_checker
// port-level checks on the point sequence of the bezier split block
// ----------------------------------------------------------------------------
`include "bezier_subdivide_at_t_macros.svh"

module bsat_checker import bsat_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COORD_WIDTH-1:0] rsp_out_x,
   input logic signed [COORD_WIDTH-1:0] rsp_out_y,
   input logic        [2:0]             rsp_point_index,
   input logic                          rsp_last
);

   // a stalled point beat stays put
   `BSAT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_point_index) && $stable(rsp_last))

   // points of one segment follow without gaps
   `BSAT_ASSERT_NEXT(a_idx_step, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid && (rsp_point_index == $past(rsp_point_index) + 3'd1))

   // a new segment starts from its first point
   `BSAT_ASSERT_NEXT(a_idx_restart, clock, reset, rsp_valid && !rsp_stall && rsp_last, !rsp_valid || (rsp_point_index == 3'd0))

   // final marker only at the end of a quadratic or a cubic
   `BSAT_ASSERT_NOW(a_last_pos, clock, reset, rsp_valid && rsp_last, (rsp_point_index == LAST_IDX_QUAD) || (rsp_point_index == LAST_IDX_CUBIC))

   // position never beyond the cubic range
   `BSAT_ASSERT_NOW(a_idx_range, clock, reset, rsp_valid, rsp_point_index <= LAST_IDX_CUBIC)

endmodule

bind bezier_subdivide_at_t bsat_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_bsat_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_x       (rsp_out_x),
   .rsp_out_y       (rsp_out_y),
   .rsp_point_index (rsp_point_index),
   .rsp_last        (rsp_last)
);
